/* src/cnv_pkg.sv */
package cnv_pkg;

    // request codes on the input word
    localparam logic [2:0] REQ_WEIGHT  = 3'd0;
    localparam logic [2:0] REQ_MAIN_LO = 3'd1;
    localparam logic [2:0] REQ_MAIN_HI = 3'd2;
    localparam logic [2:0] REQ_SKIP    = 3'd3;
    localparam logic [2:0] REQ_RUN     = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_IMAGE_WIDTH     = 3'd0;
    localparam logic [2:0] CFG_MAIN_CHANNELS   = 3'd1;
    localparam logic [2:0] CFG_OUT_CHANNELS    = 3'd2;
    localparam logic [2:0] CFG_SKIP_CHANNELS   = 3'd3;
    localparam logic [2:0] CFG_MAIN_SHIFT      = 3'd4;
    localparam logic [2:0] CFG_SKIP_CONV_SHIFT = 3'd5;
    localparam logic [2:0] CFG_RESIDUAL_SHIFT  = 3'd6;

    // element index width (covers every computed weight and activation index)
    localparam int IDXW = 16;
    // accumulator width: at most 120 products of 17 bits
    localparam int ACCW = 24;
    // working width of the rounding shifter
    localparam int RSW  = 34;

    typedef enum logic [1:0] {
        SRC_LO,
        SRC_HI,
        SRC_SK
    } t_src;

    typedef struct packed {
        logic [5:0] image_width;
        logic [6:0] main_channels;
        logic [6:0] out_channels;
        logic [6:0] skip_channels;
        logic [4:0] main_shift;
        logic [4:0] skip_conv_shift;
        logic [4:0] residual_shift;
    } t_cfg;

    // controller to datapath command
    typedef struct packed {
        logic            wr_w;
        logic            wr_lo;
        logic            wr_hi;
        logic            wr_sk;
        logic            rd;
        t_src            src;
        logic [IDXW-1:0] widx;
        logic [IDXW-1:0] aidx;
        logic            wok;
        logic            aok;
        logic            fin;
        logic [4:0]      col;
        logic            last;
    } t_cmd;

    // floor((v + 2^(s-1)) / 2^s), no rounding term for s == 0
    function automatic logic signed [RSW-1:0] round_shift(input logic signed [RSW-1:0] v,
                                                          input logic [4:0] s);
        logic signed [RSW-1:0] bias;
        bias = '0;
        if (s != 5'd0) begin
            bias[s - 5'd1] = 1'b1;
        end
        return (v + bias) >>> s;
    endfunction

    function automatic logic signed [7:0] clip_s8(input logic signed [RSW-1:0] v);
        logic signed [7:0] r;
        if (v > 34'sd127) begin
            r = 8'sd127;
        end else if (v < -34'sd128) begin
            r = -8'sd128;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] clip_u8(input logic signed [RSW-1:0] v);
        logic [7:0] r;
        if (v > 34'sd255) begin
            r = 8'd255;
        end else if (v < 34'sd0) begin
            r = 8'd0;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

/* src/conv1x1_residual_int8.sv */
// Channel   | Ports                                            | Handshake
// input     | i_req_type, i_address, i_byte_value, i_channel   | start high, busy low
// config    | i_cfg_we, i_cfg_index, i_cfg_data                | i_cfg_we high
// result    | o_column, o_pixel_value, o_last                  | o_valid strobe, one cycle
//
// Loads never raise busy. A run works through each column in main steps, skip
// steps, a pipeline drain and a finish, one multiply-accumulate per cycle in the
// main and skip steps, set by the single read port of the weight store. Each result
// leaves through a finish stage and the output register once its column finishes.
// Reset is synchronous, active low, and restores the register defaults; the stores
// are undefined until loaded. Results cannot be held off by the receiver.
module conv1x1_residual_int8 import cnv_pkg::*; #(
    parameter int MAX_WIDTH   = 32,
    parameter int MAX_MAIN_CH = 64,
    parameter int MAX_OUT_CH  = 64,
    parameter int MAX_SKIP_CH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [12:0] i_address,
    input  logic [7:0]  i_byte_value,
    input  logic [5:0]  i_channel,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    output logic        o_valid,
    output logic [4:0]  o_column,
    output logic [7:0]  o_pixel_value,
    output logic        o_last
);

    t_cfg r_cfg;
    t_cmd cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width     <= 6'd32;
            r_cfg.main_channels   <= 7'd64;
            r_cfg.out_channels    <= 7'd64;
            r_cfg.skip_channels   <= 7'd64;
            r_cfg.main_shift      <= 5'd10;
            r_cfg.skip_conv_shift <= 5'd10;
            r_cfg.residual_shift  <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:     r_cfg.image_width     <= i_cfg_data[5:0];
                CFG_MAIN_CHANNELS:   r_cfg.main_channels   <= i_cfg_data;
                CFG_OUT_CHANNELS:    r_cfg.out_channels    <= i_cfg_data;
                CFG_SKIP_CHANNELS:   r_cfg.skip_channels   <= i_cfg_data;
                CFG_MAIN_SHIFT:      r_cfg.main_shift      <= i_cfg_data[4:0];
                CFG_SKIP_CONV_SHIFT: r_cfg.skip_conv_shift <= i_cfg_data[4:0];
                CFG_RESIDUAL_SHIFT:  r_cfg.residual_shift  <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    cnv_ctrl #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_MAIN_CH (MAX_MAIN_CH),
        .MAX_OUT_CH  (MAX_OUT_CH),
        .MAX_SKIP_CH (MAX_SKIP_CH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req_type (i_req_type),
        .i_address  (i_address),
        .i_channel  (i_channel),
        .i_cfg      (r_cfg),
        .o_cmd      (cmd)
    );

    cnv_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_MAIN_CH (MAX_MAIN_CH),
        .MAX_OUT_CH  (MAX_OUT_CH),
        .MAX_SKIP_CH (MAX_SKIP_CH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (r_cfg),
        .i_address     (i_address),
        .i_byte_value  (i_byte_value),
        .o_valid       (o_valid),
        .o_column      (o_column),
        .o_pixel_value (o_pixel_value),
        .o_last        (o_last)
    );

endmodule

/* src/cnv_ctrl.sv */
module cnv_ctrl import cnv_pkg::*; #(
    parameter int MAX_WIDTH   = 32,
    parameter int MAX_MAIN_CH = 64,
    parameter int MAX_OUT_CH  = 64,
    parameter int MAX_SKIP_CH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [12:0] i_address,
    input  logic [5:0]  i_channel,
    input  t_cfg        i_cfg,
    output t_cmd        o_cmd
);

    localparam int WEIGHT_DEPTH = MAX_OUT_CH * (MAX_MAIN_CH + MAX_SKIP_CH);
    localparam int HALF_DEPTH   = MAX_WIDTH * MAX_MAIN_CH / 2;
    localparam int SKIP_DEPTH   = MAX_WIDTH * MAX_SKIP_CH;
    localparam int WW           = $clog2(MAX_WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAIN,
        S_SKIP,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state          r_state;
    logic [WW-1:0]   r_w;
    logic [WW-1:0]   r_x;
    logic [6:0]      r_step;
    logic [1:0]      r_drain;
    logic [2:0]      r_lane;
    logic [2:0]      r_mh;
    logic [3:0]      r_sb;
    logic [12:0]     r_wrow;
    logic [12:0]     r_srow;
    logic [13:0]     r_woff;

    logic            accept;
    logic            run_ok;
    logic [WW-1:0]   w_clamp;
    t_state          first_st;
    t_state          col_st;
    logic [3:0]      blk;
    logic [2:0]      lsel;
    logic [3:0]      wb;
    logic [WW+3:0]   bw;
    logic [IDXW-1:0] ai;
    logic [IDXW-1:0] wi;
    logic [6:0]      mcnt;
    logic [6:0]      scnt;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // run admission and row width clamp
    assign w_clamp = (int'(i_cfg.image_width) > MAX_WIDTH) ? WW'(MAX_WIDTH)
                                                          : WW'(i_cfg.image_width);
    assign run_ok  = ({1'b0, i_channel} < {i_cfg.out_channels[6:3], 3'b000}) &&
                     (w_clamp != '0);

    // first phase of a column, live config at start, latched counts later
    always_comb begin
        if (i_cfg.main_channels[6:4] != 3'd0) begin
            first_st = S_MAIN;
        end else if (i_cfg.skip_channels[6:3] != 4'd0) begin
            first_st = S_SKIP;
        end else begin
            first_st = S_DRAIN;
        end
        if (r_mh != 3'd0) begin
            col_st = S_MAIN;
        end else if (r_sb != 4'd0) begin
            col_st = S_SKIP;
        end else begin
            col_st = S_DRAIN;
        end
    end

    assign mcnt = {r_mh, 4'b0000};
    assign scnt = {r_sb, 3'b000};

    // element index generation for the current step
    always_comb begin
        if (r_state == S_MAIN) begin
            blk  = {1'b0, r_step[6:4]};
            lsel = r_step[3:1];
            wb   = blk + (r_step[0] ? {1'b0, r_mh} : 4'd0);
            wi   = IDXW'(r_wrow) + IDXW'({wb, 6'b000000}) + IDXW'({lsel, 3'b000})
                 + IDXW'(r_lane);
        end else begin
            blk  = r_step[6:3];
            lsel = r_step[2:0];
            wb   = blk;
            wi   = IDXW'(r_srow) + IDXW'({wb, 6'b000000}) + IDXW'({lsel, 3'b000})
                 + IDXW'(r_lane) + IDXW'(r_woff);
        end
        bw = (WW + 4)'(blk * r_w);
        ai = IDXW'({bw, 3'b000}) + IDXW'({r_x, 3'b000}) + IDXW'(lsel);
    end

    // command to the datapath
    always_comb begin
        o_cmd       = '0;
        o_cmd.src   = SRC_SK;
        o_cmd.wr_w  = accept && (i_req_type == REQ_WEIGHT)  && (int'(i_address) < WEIGHT_DEPTH);
        o_cmd.wr_lo = accept && (i_req_type == REQ_MAIN_LO) && (int'(i_address) < HALF_DEPTH);
        o_cmd.wr_hi = accept && (i_req_type == REQ_MAIN_HI) && (int'(i_address) < HALF_DEPTH);
        o_cmd.wr_sk = accept && (i_req_type == REQ_SKIP)    && (int'(i_address) < SKIP_DEPTH);
        o_cmd.widx  = wi;
        o_cmd.aidx  = ai;
        o_cmd.wok   = int'(wi) < WEIGHT_DEPTH;
        o_cmd.col   = 5'(r_x);
        o_cmd.last  = (r_x == r_w - WW'(1));
        case (r_state)
            S_MAIN: begin
                o_cmd.rd  = 1'b1;
                o_cmd.src = r_step[0] ? SRC_HI : SRC_LO;
                o_cmd.aok = int'(ai) < HALF_DEPTH;
            end
            S_SKIP: begin
                o_cmd.rd  = 1'b1;
                o_cmd.src = SRC_SK;
                o_cmd.aok = int'(ai) < SKIP_DEPTH;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer: main steps, skip steps, pipeline drain, finish per column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_x     <= '0;
            r_step  <= '0;
            r_drain <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_req_type == REQ_RUN) && run_ok) begin
                        r_w     <= w_clamp;
                        r_lane  <= i_channel[2:0];
                        r_mh    <= i_cfg.main_channels[6:4];
                        r_sb    <= i_cfg.skip_channels[6:3];
                        r_wrow  <= 13'(i_channel[5:3] * i_cfg.main_channels[6:3]) << 6;
                        r_srow  <= 13'(i_channel[5:3] * i_cfg.skip_channels[6:3]) << 6;
                        r_woff  <= 14'(i_cfg.out_channels * i_cfg.main_channels);
                        r_x     <= '0;
                        r_step  <= '0;
                        r_drain <= '0;
                        r_state <= first_st;
                    end
                end
                S_MAIN: begin
                    if (r_step == mcnt - 7'd1) begin
                        r_step  <= '0;
                        r_state <= (r_sb != 4'd0) ? S_SKIP : S_DRAIN;
                    end else begin
                        r_step <= r_step + 7'd1;
                    end
                end
                S_SKIP: begin
                    if (r_step == scnt - 7'd1) begin
                        r_step  <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_step <= r_step + 7'd1;
                    end
                end
                S_DRAIN: begin
                    if (r_drain == 2'd2) begin
                        r_drain <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_drain <= r_drain + 2'd1;
                    end
                end
                S_FIN: begin
                    if (r_x == r_w - WW'(1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_x     <= r_x + WW'(1);
                        r_state <= col_st;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_fin_no_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> !o_cmd.rd)
        else $error("finish issued together with a read");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!o_cmd.rd && !o_cmd.fin))
        else $error("datapath command while idle");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.fin && o_cmd.last) |=> (r_state == S_IDLE))
        else $error("run did not end after last column");

endmodule

/* src/cnv_dp.sv */
module cnv_dp import cnv_pkg::*; #(
    parameter int MAX_WIDTH   = 32,
    parameter int MAX_MAIN_CH = 64,
    parameter int MAX_OUT_CH  = 64,
    parameter int MAX_SKIP_CH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_cfg        i_cfg,
    input  logic [12:0] i_address,
    input  logic [7:0]  i_byte_value,
    output logic        o_valid,
    output logic [4:0]  o_column,
    output logic [7:0]  o_pixel_value,
    output logic        o_last
);

    localparam int WEIGHT_DEPTH = MAX_OUT_CH * (MAX_MAIN_CH + MAX_SKIP_CH);
    localparam int HALF_DEPTH   = MAX_WIDTH * MAX_MAIN_CH / 2;
    localparam int SKIP_DEPTH   = MAX_WIDTH * MAX_SKIP_CH;
    localparam int WDB          = $clog2(WEIGHT_DEPTH);
    localparam int HDB          = $clog2(HALF_DEPTH);
    localparam int SDB          = $clog2(SKIP_DEPTH);

    logic [7:0] w_mem  [0:WEIGHT_DEPTH-1];
    logic [7:0] lo_mem [0:HALF_DEPTH-1];
    logic [7:0] hi_mem [0:HALF_DEPTH-1];
    logic [7:0] sk_mem [0:SKIP_DEPTH-1];

    logic [7:0]              r_w_q;
    logic [7:0]              r_lo_q;
    logic [7:0]              r_hi_q;
    logic [7:0]              r_sk_q;
    logic                    r_s1_v;
    t_src                    r_s1_src;
    logic                    r_s1_ok;
    logic                    r_s2_v;
    logic                    r_s2_sk;
    logic signed [17:0]      r_p;
    logic signed [ACCW-1:0]  r_macc;
    logic signed [ACCW-1:0]  r_sacc;
    logic                    r_fa_v;
    logic signed [7:0]       r_mv;
    logic signed [7:0]       r_sv;
    logic [4:0]              r_fa_col;
    logic                    r_fa_last;

    logic signed [8:0]       act;
    logic signed [17:0]      prod;
    logic signed [RSW-1:0]   res_sum;

    // weight store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_w) begin
            w_mem[WDB'(i_address)] <= i_byte_value;
        end
        if (i_cmd.rd && i_cmd.wok) begin
            r_w_q <= w_mem[WDB'(i_cmd.widx)];
        end
    end

    // main activation low half
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_lo) begin
            lo_mem[HDB'(i_address)] <= i_byte_value;
        end
        if (i_cmd.rd && i_cmd.aok && (i_cmd.src == SRC_LO)) begin
            r_lo_q <= lo_mem[HDB'(i_cmd.aidx)];
        end
    end

    // main activation high half
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_hi) begin
            hi_mem[HDB'(i_address)] <= i_byte_value;
        end
        if (i_cmd.rd && i_cmd.aok && (i_cmd.src == SRC_HI)) begin
            r_hi_q <= hi_mem[HDB'(i_cmd.aidx)];
        end
    end

    // skip activations
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_sk) begin
            sk_mem[SDB'(i_address)] <= i_byte_value;
        end
        if (i_cmd.rd && i_cmd.aok && (i_cmd.src == SRC_SK)) begin
            r_sk_q <= sk_mem[SDB'(i_cmd.aidx)];
        end
    end

    // operand select; out-of-range reads count as zero
    always_comb begin
        case (r_s1_src)
            SRC_LO:  act = $signed({1'b0, r_lo_q});
            SRC_HI:  act = $signed({1'b0, r_hi_q});
            SRC_SK:  act = $signed({r_sk_q[7], r_sk_q});
            default: act = '0;
        endcase
        prod = r_s1_ok ? ($signed({r_w_q[7], r_w_q}) * act) : 18'sd0;
    end

    assign res_sum = RSW'(r_mv) + RSW'(r_sv);

    // tag pipe, multiply, accumulate, requantize
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_fa_v  <= 1'b0;
            o_valid <= 1'b0;
            r_macc  <= '0;
            r_sacc  <= '0;
        end else begin
            r_s1_v   <= i_cmd.rd;
            r_s1_src <= i_cmd.src;
            r_s1_ok  <= i_cmd.wok && i_cmd.aok;
            r_s2_v   <= r_s1_v;
            r_s2_sk  <= (r_s1_src == SRC_SK);
            r_p      <= prod;
            if (i_cmd.fin) begin
                r_macc <= '0;
                r_sacc <= '0;
            end else if (r_s2_v) begin
                if (r_s2_sk) begin
                    r_sacc <= r_sacc + ACCW'(r_p);
                end else begin
                    r_macc <= r_macc + ACCW'(r_p);
                end
            end
            r_fa_v    <= i_cmd.fin;
            r_fa_col  <= i_cmd.col;
            r_fa_last <= i_cmd.last;
            r_mv      <= clip_s8(round_shift(RSW'(r_macc), i_cfg.main_shift));
            r_sv      <= clip_s8(round_shift(RSW'(r_sacc), i_cfg.skip_conv_shift));
            o_valid       <= r_fa_v;
            o_column      <= r_fa_col;
            o_last        <= r_fa_last;
            o_pixel_value <= clip_u8(round_shift(res_sum, i_cfg.residual_shift));
        end
    end

    a_out_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_cmd.fin, 2))
        else $error("result word without a finish command");

    a_s1_from_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |-> $past(i_cmd.rd))
        else $error("read stage valid without a read");

    a_no_acc_at_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |-> !r_s2_v)
        else $error("product still in flight at finish");

endmodule
